>>> hw/rtl/cst_pkg.sv
// Shared types and constants of the command slot tracker.
package cst_pkg;

   // Field widths of the channels.
   localparam int OP_W    = 2;
   localparam int BITS_W  = 32;
   localparam int SLOT_W  = 5;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 6;

   // Operation codes of a request word.
   localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [OP_W-1:0] OP_START    = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPLETE = 2'd2;

   // Status codes of a response word.
   localparam logic [STAT_W-1:0] ST_GRANTED   = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_ISSUED    = 3'd2;
   localparam logic [STAT_W-1:0] ST_COMPLETED = 3'd3;
   localparam logic [STAT_W-1:0] ST_SPURIOUS  = 3'd4;
   localparam logic [STAT_W-1:0] ST_NONE      = 3'd5;

   // Verdict of the slot evaluator for one slot.
   typedef struct packed {
      logic               hit;
      logic [STAT_W-1:0]  status;
      logic               set_pend;
      logic               set_iss;
      logic               retire;
   } slot_eval_type;

   // Word handed from the sequencer to the response register.
   typedef struct packed {
      logic               valid;
      logic [SLOT_W-1:0]  slot;
      logic [STAT_W-1:0]  status;
      logic               last;
   } push_type;

endpackage

>>> hw/rtl/cst_if.sv
// Channel interfaces of the command slot tracker: request, response and register write.

interface cst_req_if import cst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BITS_W-1:0] issue_bits;
   modport source (output valid, operation, issue_bits, input ready);
   modport sink (input valid, operation, issue_bits, output ready);
endinterface

interface cst_rsp_if import cst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot;
   logic [STAT_W-1:0] status;
   logic              last;
   modport source (output valid, slot, status, last, input ready);
   modport sink (input valid, slot, status, last, output ready);
endinterface

interface cst_csr_if import cst_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] slot_count;
   modport source (output valid, slot_count, input ready);
   modport sink (input valid, slot_count, output ready);
endinterface

>>> hw/rtl/cst_slot_eval.sv
// Shared per-slot evaluator: decides what one slot yields for the current operation.
module cst_slot_eval import cst_pkg::*; (
   input  logic [OP_W-1:0] operation,
   input  logic            pend_bit,
   input  logic            iss_bit,
   input  logic            ci_bit,
   output slot_eval_type   verdict
);

   // Decode the operation against the slot's two state bits.
   always_comb begin
      verdict = '0;
      verdict.status = ST_NONE;
      case (operation)
         OP_ENQUEUE: begin
            verdict.hit      = !pend_bit;
            verdict.status   = ST_GRANTED;
            verdict.set_pend = !pend_bit;
         end
         OP_START: begin
            verdict.hit     = pend_bit && !iss_bit;
            verdict.status  = ST_ISSUED;
            verdict.set_iss = pend_bit && !iss_bit;
         end
         OP_COMPLETE: begin
            verdict.hit    = pend_bit && !ci_bit;
            verdict.status = iss_bit ? ST_COMPLETED : ST_SPURIOUS;
            verdict.retire = pend_bit && !ci_bit && iss_bit;
         end
         default: begin
            verdict.hit = 1'b0;
         end
      endcase
   end

endmodule

>>> hw/rtl/cst_seq.sv
// Scan sequencer: holds the slot bitmaps and walks the slots one per cycle while no hit waits on the response register.
module cst_seq import cst_pkg::*; #(
   parameter int MAX_SLOTS = 32
) (
   input  logic               clock,
   input  logic               reset,
   cst_req_if.sink            req_ch,
   input  logic [COUNT_W-1:0] slot_count,
   input  logic               push_ready,
   output push_type           push
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [BITS_W-1:0]    ci_ff, ci_in;
   logic [MAX_SLOTS-1:0] pend_ff, pend_in;
   logic [MAX_SLOTS-1:0] iss_ff, iss_in;
   logic                 hold_valid_ff, hold_valid_in;
   logic [SLOT_W-1:0]    hold_slot_ff, hold_slot_in;
   logic [STAT_W-1:0]    hold_stat_ff, hold_stat_in;

   logic [CNT_W-1:0]     active_n;
   logic [IDX_W-1:0]     idx;
   logic                 stall;
   slot_eval_type        verdict;

   // Effective slot count saturates at the slot limit.
   assign active_n = (slot_count > COUNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                      : CNT_W'(slot_count);
   assign idx = cnt_ff[IDX_W-1:0];

   // The one evaluator shared by every slot of the scan.
   cst_slot_eval u_eval (
      .operation (op_ff),
      .pend_bit  (pend_ff[idx]),
      .iss_bit   (iss_ff[idx]),
      .ci_bit    (ci_ff[idx]),
      .verdict   (verdict)
   );

   assign req_ch.ready = (state_ff == S_IDLE);

   // A new hit can only park once the held word has somewhere to go.
   assign stall = verdict.hit && hold_valid_ff && !push_ready;

   // Sequencer next state and response word.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      ci_in         = ci_ff;
      pend_in       = pend_ff;
      iss_in        = iss_ff;
      hold_valid_in = hold_valid_ff;
      hold_slot_in  = hold_slot_ff;
      hold_stat_in  = hold_stat_ff;
      push          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_ch.operation;
               ci_in         = req_ch.issue_bits;
               cnt_in        = '0;
               hold_valid_in = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff >= active_n) begin
               state_in = S_FLUSH;
            end else if (!stall) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (verdict.hit) begin
                  // The earlier hit is not the last one; send it on.
                  push.valid    = hold_valid_ff;
                  push.slot     = hold_slot_ff;
                  push.status   = hold_stat_ff;
                  push.last     = 1'b0;
                  hold_valid_in = 1'b1;
                  hold_slot_in  = SLOT_W'(cnt_ff);
                  hold_stat_in  = verdict.status;
                  if (verdict.set_pend) begin
                     pend_in[idx] = 1'b1;
                  end
                  if (verdict.set_iss) begin
                     iss_in[idx] = 1'b1;
                  end
                  if (verdict.retire) begin
                     pend_in[idx] = 1'b0;
                     iss_in[idx]  = 1'b0;
                  end
                  if (op_ff == OP_ENQUEUE) begin
                     state_in = S_FLUSH;
                  end
               end
            end
         end
         S_FLUSH: begin
            // Final word of the item: the held hit, or full or none.
            push.valid = push_ready;
            push.last  = 1'b1;
            if (hold_valid_ff) begin
               push.slot   = hold_slot_ff;
               push.status = hold_stat_ff;
            end else begin
               push.slot   = '0;
               push.status = (op_ff == OP_ENQUEUE) ? ST_FULL : ST_NONE;
            end
            if (push_ready) begin
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and bitmaps.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         pend_ff       <= '0;
         iss_ff        <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         iss_ff        <= iss_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Item payload and held response word.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ci_ff        <= ci_in;
      hold_slot_ff <= hold_slot_in;
      hold_stat_ff <= hold_stat_in;
   end

`ifndef SYNTHESIS
   // An issued slot is always a pending slot.
   a_iss_subset: assert property (@(posedge clock) disable iff (reset)
      (iss_ff & ~pend_ff) == '0)
      else $error("issued slot that is not pending");

   // Only the flush step closes an item.
   a_last_in_flush: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.last) |-> (state_ff == S_FLUSH))
      else $error("final word outside flush");

   // No word is held while a new item can be taken.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !hold_valid_ff)
      else $error("held word while idle");

   // A word is pushed only when the response register can take it.
   a_push_ready: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push_ready)
      else $error("word pushed into a full response register");
`endif

endmodule

>>> hw/rtl/command_slot_tracker.sv
// Command slot tracker top level: slot count register, sequencer and response register.
// An item is accepted, the slots below the effective slot count are scanned one at a time,
// then an end-of-scan step and a flush step follow.
// Enqueue stops its scan at the first free slot and goes straight to flush. The single shared
// slot evaluator makes the scan serial; the scan pauses while the response register is held by the sink.
// Reset clears both bitmaps, sets the slot count to 32 and empties the response register.
module command_slot_tracker import cst_pkg::*; #(
   parameter int MAX_SLOTS = 32
) (
   input  logic      clock,
   input  logic      reset,
   cst_req_if.sink   req_ch,
   cst_rsp_if.source rsp_ch,
   cst_csr_if.sink   csr_ch
);

   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

   logic [COUNT_W-1:0] slot_count_ff, slot_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               push_ready;
   push_type           push;

   cst_seq #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .slot_count (slot_count_ff),
      .push_ready (push_ready),
      .push       (push)
   );

   // Slot count register write.
   assign csr_ch.ready  = 1'b1;
   assign slot_count_in = csr_ch.valid ? csr_ch.slot_count : slot_count_ff;

   // Response register: loads a word whenever it is empty or being drained.
   assign push_ready   = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in = push.valid ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_slot_in  = push.valid ? push.slot   : rsp_slot_ff;
   assign rsp_stat_in  = push.valid ? push.status : rsp_stat_ff;
   assign rsp_last_in  = push.valid ? push.last   : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_count_ff <= slot_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff <= rsp_slot_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.slot   = rsp_slot_ff;
   assign rsp_ch.status = rsp_stat_ff;
   assign rsp_ch.last   = rsp_last_ff;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the command slot tracker against a slot-bitmap predictor.
module tb;
   import cst_pkg::*;

   localparam int SLOT_LIMIT = 32;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_WORDS = 100;
   localparam int SEGMENT_WORDS = 20;
   localparam int SHOWN_MISMATCHES = 100;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [STAT_W-1:0] status;
      logic              last;
   } slot_result_type;

   logic clock = 1'b0;
   logic reset;

   cst_req_if req_bus ();
   cst_rsp_if rsp_bus ();
   cst_csr_if csr_bus ();

   command_slot_tracker #(.MAX_SLOTS(SLOT_LIMIT)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Tracked copy of the slot count and of both slot bitmaps.
   logic [COUNT_W-1:0] slot_count_q = COUNT_W'(SLOT_LIMIT);
   logic [BITS_W-1:0]  pending_q = '0;
   logic [BITS_W-1:0]  issued_q = '0;
   slot_result_type    slot_results_due[$];

   int fail_count = 0;
   int words_sent = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Number of slots that the tracker grants and scans, saturated at the slot limit.
   function automatic int scan_limit();
      return (int'(slot_count_q) > SLOT_LIMIT) ? SLOT_LIMIT : int'(slot_count_q);
   endfunction

   function automatic void note_result(input int slot_no, input logic [STAT_W-1:0] status);
      slot_result_type entry;
      entry.slot = SLOT_W'(slot_no);
      entry.status = status;
      entry.last = 1'b0;
      slot_results_due.push_back(entry);
   endfunction

   // Applies one request word to the tracked bitmaps and queues the response words.
   task automatic track_command(input logic [OP_W-1:0] op, input logic [BITS_W-1:0] bits);
      int n;
      int first;
      bit granted;
      slot_result_type tail;
      n = scan_limit();
      first = slot_results_due.size();
      granted = 1'b0;
      case (op)
         OP_ENQUEUE: begin
            // The lowest free slot below the count is granted.
            for (int i = 0; i < n; i++) begin
               if (!granted && !pending_q[i]) begin
                  pending_q[i] = 1'b1;
                  note_result(i, ST_GRANTED);
                  granted = 1'b1;
               end
            end
            if (!granted) note_result(0, ST_FULL);
         end
         OP_START: begin
            for (int i = 0; i < n; i++) begin
               if (pending_q[i] && !issued_q[i]) begin
                  issued_q[i] = 1'b1;
                  note_result(i, ST_ISSUED);
               end
            end
         end
         OP_COMPLETE: begin
            // A cleared issue bit retires an issued slot and flags one that was never issued.
            for (int i = 0; i < n; i++) begin
               if (pending_q[i] && !bits[i]) begin
                  if (issued_q[i]) begin
                     issued_q[i] = 1'b0;
                     pending_q[i] = 1'b0;
                     note_result(i, ST_COMPLETED);
                  end else begin
                     note_result(i, ST_SPURIOUS);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (slot_results_due.size() == first) note_result(0, ST_NONE);
      tail = slot_results_due[$];
      tail.last = 1'b1;
      slot_results_due[slot_results_due.size() - 1] = tail;
   endtask

   task automatic report_mismatch(input string what);
      if (fail_count < SHOWN_MISMATCHES) $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   // Response sink stalls at random according to the current phase.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Each accepted response word is compared with the oldest expected one.
   always @(posedge clock) begin : check_words
      slot_result_type due;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (slot_results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word slot %0d status %0d last %0b",
                                      rsp_bus.slot, rsp_bus.status, rsp_bus.last));
         end else begin
            due = slot_results_due.pop_front();
            if (rsp_bus.slot !== due.slot)
               report_mismatch($sformatf("slot %0d, expected %0d", rsp_bus.slot, due.slot));
            if (rsp_bus.status !== due.status)
               report_mismatch($sformatf("status %0d, expected %0d (slot %0d)",
                                         rsp_bus.status, due.status, due.slot));
            if (rsp_bus.last !== due.last)
               report_mismatch($sformatf("last %0b, expected %0b (slot %0d)",
                                         rsp_bus.last, due.last, due.slot));
         end
      end
   end

   // Sends one request word after a random idle gap and predicts its responses.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [BITS_W-1:0] bits);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.issue_bits <= bits;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      track_command(op, bits);
      words_sent++;
   endtask

   // Stops sending and waits until every expected response word has arrived.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (slot_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [COUNT_W-1:0] value);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.slot_count <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      slot_count_q = value;
   endtask

   // Grant, issue, completion, spurious completion and the empty cases at the reset count.
   task automatic test_grant_issue_complete();
      repeat (3) send_word(OP_ENQUEUE, '0);
      send_word(OP_START, '1);
      send_word(OP_ENQUEUE, '1);
      send_word(OP_COMPLETE, 32'hFFFF_FFFA);
      send_word(OP_COMPLETE, '0);
      send_word(OP_START, 32'h5555_5555);
      send_word(OP_START, 32'hAAAA_AAAA);
      send_word(OP_UNUSED, '1);
      send_word(OP_COMPLETE, '1);
      send_word(OP_COMPLETE, '0);
   endtask

   // Full tracker, zero count, saturated count and slots left above a lowered count.
   task automatic test_slot_count_limits();
      write_slot_count(COUNT_W'(1));
      send_word(OP_ENQUEUE, '0);
      send_word(OP_ENQUEUE, '0);
      send_word(OP_START, '0);
      send_word(OP_COMPLETE, 32'hFFFF_FFFE);
      write_slot_count('0);
      send_word(OP_ENQUEUE, '0);
      send_word(OP_START, '0);
      send_word(OP_COMPLETE, '0);
      write_slot_count(COUNT_W'(3));
      repeat (3) send_word(OP_ENQUEUE, '0);
      write_slot_count(COUNT_W'(2));
      send_word(OP_START, '0);
      send_word(OP_COMPLETE, '0);
      write_slot_count('1);
      send_word(OP_ENQUEUE, '0);
      send_word(OP_START, '0);
      send_word(OP_COMPLETE, '0);
   endtask

   // One burst: a run of enqueues, an optional early completion, a start and completions.
   task automatic run_slot_sequence();
      int grants;
      grants = $urandom_range(1, scan_limit() + 2);
      repeat (grants) send_word(OP_ENQUEUE, $urandom());
      if ($urandom_range(1) == 1) send_word(OP_COMPLETE, ~(pending_q & $urandom()));
      send_word(OP_START, $urandom());
      repeat ($urandom_range(1, 2)) send_word(OP_COMPLETE, ~(pending_q & $urandom()));
   endtask

   // Random traffic in four idling phases, with a new slot count for each segment.
   task automatic test_random_traffic();
      int send_mix[4] = '{0, 61, 0, 26};
      int stall_mix[4] = '{0, 0, 61, 26};
      int phase_start;
      int segment_start;
      logic [COUNT_W-1:0] count_pick;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_mix[phase];
         stall_pct = stall_mix[phase];
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            case ($urandom_range(11))
               0: count_pick = '0;
               1: count_pick = COUNT_W'(1);
               2, 3: count_pick = COUNT_W'(SLOT_LIMIT);
               4: count_pick = '1;
               default: count_pick = COUNT_W'($urandom_range(2, SLOT_LIMIT - 1));
            endcase
            write_slot_count(count_pick);
            segment_start = words_sent;
            while (words_sent - segment_start < SEGMENT_WORDS) begin
               if ($urandom_range(9) < 7) run_slot_sequence();
               else send_word(OP_W'($urandom_range(3)), $urandom());
            end
         end
      end
   endtask

   // Reset, the test sequence and the final verdict.
   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_ENQUEUE;
      req_bus.issue_bits <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.slot_count <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_grant_issue_complete();
      test_slot_count_limits();
      test_random_traffic();
      wait_idle();
      repeat (SLOT_LIMIT + 2) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin
      #10ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
